FILE: hw/rtl/xorshift128plus_prng_macros.svh
// Assertion macros for the xorshift128+ generator.
`ifndef XORSHIFT128PLUS_PRNG_MACROS_SVH
`define XORSHIFT128PLUS_PRNG_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge out of reset.
`define XSP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xorshift128plus_prng: assertion failed");
// Next-cycle implication.
`define XSP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xorshift128plus_prng: assertion failed");
`else
`define XSP_ASSERT_IMP(label, ante, cons)
`define XSP_ASSERT_NXT(label, ante, cons)
`endif
`endif

FILE: hw/rtl/xsp_pkg.sv
// Shared types and constants for the xorshift128+ generator.
package xsp_pkg;

  // Request codes
  localparam logic CMD_NEXT   = 1'b0;
  localparam logic CMD_RESEED = 1'b1;

  // Seed-mixing constants
  localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_ONE  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [63:0] MIX_MUL_TWO  = 64'h94D0_49BB_1331_11EB;

  // Mix shifts
  localparam int unsigned MIX_SHIFT_A = 30;
  localparam int unsigned MIX_SHIFT_B = 27;
  localparam int unsigned MIX_SHIFT_C = 31;

  // Step shifts
  localparam int unsigned STEP_SHIFT_A = 23;
  localparam int unsigned STEP_SHIFT_B = 18;
  localparam int unsigned STEP_SHIFT_C = 5;

  // State after reset: the two mixed words of seed zero
  localparam logic [63:0] RESET_FIRST_WORD  = 64'hE220_A839_7B1D_CDAF;
  localparam logic [63:0] RESET_SECOND_WORD = 64'h6E78_9E6A_A1B9_65F4;

  // Multiplier request and response
  typedef struct packed {
    logic        start;
    logic [63:0] op_a;
    logic [63:0] op_b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] product;
  } mul_rsp_t;

  // Seeder request and response
  typedef struct packed {
    logic        start;
    logic [63:0] seed;
  } seed_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] word0;
    logic [63:0] word1;
  } seed_rsp_t;

endpackage

FILE: hw/rtl/xsp_mul64.sv
// Iterative 64x64 multiplier, low 64 bits, one 32x32 partial product a cycle.
module xsp_mul64 (
  input  logic              clk,
  input  logic              rst_n,
  input  xsp_pkg::mul_req_t req,
  output xsp_pkg::mul_rsp_t rsp
);

  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] prod_r;
  logic [63:0] acc_r;
  logic [63:0] acc_nxt;
  logic [1:0]  step_r;
  logic        busy_r;
  logic        done_r;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [63:0] mul_out;

  // Partial product order: lo*lo, lo*hi, hi*lo (hi*hi falls off the top)
  always_comb begin
    unique case (step_r)
      2'd1: begin
        op_a = a_r[31:0];
        op_b = b_r[63:32];
      end
      2'd2: begin
        op_a = a_r[63:32];
        op_b = b_r[31:0];
      end
      default: begin
        op_a = a_r[31:0];
        op_b = b_r[31:0];
      end
    endcase
  end

  assign mul_out = 64'(op_a) * 64'(op_b);

  // Accumulate the previous cycle's product
  always_comb begin
    if (step_r == 2'd1) begin
      acc_nxt = prod_r;
    end else begin
      acc_nxt = {acc_r[63:32] + prod_r[31:0], acc_r[31:0]};
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd3) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (req.start) begin
        busy_r <= 1'b1;
        step_r <= 2'd0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (!busy_r && req.start) begin
      a_r <= req.op_a;
      b_r <= req.op_b;
    end
    if (busy_r) begin
      prod_r <= mul_out;
      if (step_r != 2'd0) begin
        acc_r <= acc_nxt;
      end
    end
  end

  assign rsp.done    = done_r;
  assign rsp.product = acc_r;

endmodule

FILE: hw/rtl/xsp_seeder.sv
// Sequencer that expands a seed into two state words via splitmix64 mixing.
module xsp_seeder (
  input  logic               clk,
  input  logic               rst_n,
  input  xsp_pkg::seed_req_t req,
  output xsp_pkg::seed_rsp_t rsp
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GAMMA = 3'd1;
  localparam logic [2:0] S_MIX1  = 3'd2;
  localparam logic [2:0] S_WAIT1 = 3'd3;
  localparam logic [2:0] S_MIX2  = 3'd4;
  localparam logic [2:0] S_WAIT2 = 3'd5;

  logic [2:0]        state_r;
  logic              idx_r;
  logic              done_r;
  logic [63:0]       seed_r;
  logic [63:0]       z_r;
  logic [63:0]       word0_r;
  logic [63:0]       word1_r;
  logic [63:0]       fin_word;
  xsp_pkg::mul_req_t mul_req;
  xsp_pkg::mul_rsp_t mul_rsp;

  xsp_mul64 u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .rsp  (mul_rsp)
  );

  // Multiplier requests for the two xor-shift-multiply rounds
  always_comb begin
    mul_req.start = (state_r == S_MIX1) || (state_r == S_MIX2);
    if (state_r == S_MIX2) begin
      mul_req.op_a = z_r ^ (z_r >> xsp_pkg::MIX_SHIFT_B);
      mul_req.op_b = xsp_pkg::MIX_MUL_TWO;
    end else begin
      mul_req.op_a = seed_r ^ (seed_r >> xsp_pkg::MIX_SHIFT_A);
      mul_req.op_b = xsp_pkg::MIX_MUL_ONE;
    end
  end

  // Final xor-shift
  assign fin_word = mul_rsp.product ^ (mul_rsp.product >> xsp_pkg::MIX_SHIFT_C);

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (req.start) begin
            idx_r   <= 1'b0;
            state_r <= S_GAMMA;
          end
        end
        S_GAMMA: state_r <= S_MIX1;
        S_MIX1:  state_r <= S_WAIT1;
        S_WAIT1: begin
          if (mul_rsp.done) begin
            state_r <= S_MIX2;
          end
        end
        S_MIX2:  state_r <= S_WAIT2;
        S_WAIT2: begin
          if (mul_rsp.done) begin
            if (!idx_r) begin
              idx_r   <= 1'b1;
              state_r <= S_GAMMA;
            end else begin
              done_r  <= 1'b1;
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && req.start) begin
      seed_r <= req.seed;
    end
    if (state_r == S_GAMMA) begin
      seed_r <= seed_r + xsp_pkg::GOLDEN_GAMMA;
    end
    if (state_r == S_WAIT1 && mul_rsp.done) begin
      z_r <= mul_rsp.product;
    end
    if (state_r == S_WAIT2 && mul_rsp.done) begin
      if (!idx_r) begin
        word0_r <= fin_word;
      end else begin
        word1_r <= fin_word;
      end
    end
  end

  assign rsp.done  = done_r;
  assign rsp.word0 = word0_r;
  assign rsp.word1 = word1_r;

endmodule

FILE: hw/rtl/xorshift128plus_prng.sv
// Top level of the xorshift128+ generator with splitmix64 reseeding.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_command, in_seed_value
//   out_     output     out_valid/out_stall out_random_word
//
// A next request leaves its word in the output register.
// A reseed request runs two mixing passes, each running two 64-bit multiplies
// through one shared 32x32 multiplier.
// The input is stalled while a reseed runs and while an unread word is held under out_stall.
// Synchronous active-low reset loads the state words for seed zero.
`include "xorshift128plus_prng_macros.svh"

module xorshift128plus_prng (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [63:0] in_seed_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_random_word
);

  logic               first_r;
  logic [63:0]        first_word_r;
  logic [63:0]        second_word_r;
  logic               seed_busy_r;
  logic               out_valid_r;
  logic [63:0]        out_word_r;
  logic               in_take;
  logic               next_take;
  logic               reseed_take;
  logic               out_take;
  logic [63:0]        mix_a;
  logic [63:0]        new_second;
  xsp_pkg::seed_req_t seed_req;
  xsp_pkg::seed_rsp_t seed_rsp;

  assign in_stall    = seed_busy_r || (out_valid_r && out_stall);
  assign in_take     = in_valid && !in_stall;
  assign next_take   = in_take && (in_command == xsp_pkg::CMD_NEXT);
  assign reseed_take = in_take && (in_command == xsp_pkg::CMD_RESEED);
  assign out_take    = out_valid_r && !out_stall;

  // Reseed unit
  assign seed_req.start = reseed_take;
  assign seed_req.seed  = in_seed_value;

  xsp_seeder u_seeder (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (seed_req),
    .rsp  (seed_rsp)
  );

  // One xorshift128+ step
  assign mix_a      = first_word_r ^ (first_word_r << xsp_pkg::STEP_SHIFT_A);
  assign new_second = mix_a ^ second_word_r ^ (mix_a >> xsp_pkg::STEP_SHIFT_B)
                      ^ (second_word_r >> xsp_pkg::STEP_SHIFT_C);

  // Generator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_word_r  <= xsp_pkg::RESET_FIRST_WORD;
      second_word_r <= xsp_pkg::RESET_SECOND_WORD;
      seed_busy_r   <= 1'b0;
      first_r       <= 1'b1;
    end else begin
      first_r <= 1'b0;
      if (seed_rsp.done) begin
        first_word_r  <= seed_rsp.word0;
        second_word_r <= seed_rsp.word1;
        seed_busy_r   <= 1'b0;
      end else if (reseed_take) begin
        seed_busy_r <= 1'b1;
      end else if (next_take) begin
        first_word_r  <= second_word_r;
        second_word_r <= new_second;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (next_take) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (next_take) begin
      out_word_r <= new_second + second_word_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_random_word = out_word_r;

  // Checks
  `XSP_ASSERT_IMP(a_no_take_while_seeding, seed_busy_r, in_stall)
  `XSP_ASSERT_IMP(a_seed_done_only_busy, seed_rsp.done, seed_busy_r)
  `XSP_ASSERT_NXT(a_next_gives_word, next_take, out_valid_r)
  `XSP_ASSERT_NXT(a_reseed_no_word, reseed_take && !out_valid_r, !out_valid_r)
  `XSP_ASSERT_IMP(a_reset_not_busy, first_r, !seed_busy_r)

endmodule
